FILE: hw/rtl/tcw_pkg.sv
// Shared types and character constants of the text console writer.
package tcw_pkg;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BLANK     = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  typedef enum logic [2:0] {
    OP_READ,
    OP_PRINT,
    OP_LINE_END,
    OP_TAB,
    OP_BACK
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  ch;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        in_range;
    logic        last;
  } tcw_op_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_line;
    logic [10:0] shown_cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } tcw_res_t;

endpackage

FILE: hw/rtl/text_console_writer.sv
// Top level of the character-cell text console writer.
// Character-cell text console of COLUMNS x ROWS cells, each holding a character
// and an attribute byte. After reset the screen store is cleared one cell per
// cycle; full stays high during that pass. Every beat then goes through a short
// operation queue to a sequencer that owns the single write port of the screen
// store, one cell per cycle. A read passes through the read state; a printable
// character or a backspace through the wrap and done states; a tab and a newline
// or carriage return first fill blank cells in the fill state.
// Scrolling moves a top-row pointer instead of copying the screen and blanks
// the new bottom row. Results come out in order through a two-entry queue.
module text_console_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic        in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  input  logic        in_last_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  out_cursor_column,
  output logic [4:0]  out_cursor_line,
  output logic [10:0] out_shown_cursor_pos,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attr
);

  import tcw_pkg::*;

  logic [7:0]                  attr_r;
  tcw_op_t                     op;
  logic                        op_valid;
  logic                        op_pop;
  logic                        op_full;
  logic                        clearing;
  logic                        res_room;
  logic                        res_push;
  logic                        res_full;
  logic                        res_valid;
  tcw_res_t                    res;
  logic [$bits(tcw_res_t)-1:0] res_q;
  tcw_res_t                    res_out;
  logic                        in_accept;

  assign full      = op_full || clearing;
  assign in_accept = push && !full;
  assign res_room  = !res_full;
  assign empty     = !res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_wr_en) begin
      attr_r <= cfg_wr_data;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .cmd          (in_cmd),
    .char_code    (in_char_code),
    .read_row     (in_read_row),
    .read_col     (in_read_col),
    .last_of_text (in_last_of_text),
    .op_pop       (op_pop),
    .op           (op),
    .op_valid     (op_valid),
    .op_full      (op_full)
  );

  tcw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .attr     (attr_r),
    .op       (op),
    .op_valid (op_valid),
    .op_pop   (op_pop),
    .res_room (res_room),
    .res_push (res_push),
    .res      (res),
    .clearing (clearing)
  );

  tcw_fifo #(
    .WIDTH ($bits(tcw_res_t)),
    .DEPTH (2)
  ) u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (res_push),
    .wr_data   (res),
    .rd_en     (pop),
    .rd_data   (res_q),
    .not_empty (res_valid),
    .is_full   (res_full)
  );

  assign res_out              = res_q;
  assign out_cursor_column    = res_out.cursor_column;
  assign out_cursor_line      = res_out.cursor_line;
  assign out_shown_cursor_pos = res_out.shown_cursor_pos;
  assign out_cell_char        = res_out.cell_char;
  assign out_cell_attr        = res_out.cell_attr;

endmodule

FILE: hw/rtl/tcw_fifo.sv
// Small register-based first-in first-out queue.
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty,
  output logic             is_full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr;
  logic             do_rd;

  assign do_wr     = wr_en && (count_r != CNT_W'(DEPTH));
  assign do_rd     = rd_en && (count_r != '0);
  assign rd_data   = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign is_full   = (count_r == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/tcw_front.sv
// Front end: classifies incoming beats into operations and queues them.
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            cmd,
  input  logic [7:0]      char_code,
  input  logic [4:0]      read_row,
  input  logic [6:0]      read_col,
  input  logic            last_of_text,
  input  logic            op_pop,
  output tcw_pkg::tcw_op_t op,
  output logic            op_valid,
  output logic            op_full
);

  import tcw_pkg::*;

  tcw_op_t                 op_in;
  logic [$bits(tcw_op_t)-1:0] op_q;

  always_comb begin
    op_in.ch       = char_code;
    op_in.row      = read_row;
    op_in.col      = read_col;
    op_in.last     = last_of_text;
    op_in.in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
    if (cmd) begin
      op_in.kind = OP_READ;
    end else if (char_code == CH_NEWLINE || char_code == CH_RETURN) begin
      op_in.kind = OP_LINE_END;
    end else if (char_code == CH_TAB) begin
      op_in.kind = OP_TAB;
    end else if (char_code == CH_BACKSPACE) begin
      op_in.kind = OP_BACK;
    end else begin
      op_in.kind = OP_PRINT;
    end
  end

  tcw_fifo #(
    .WIDTH ($bits(tcw_op_t)),
    .DEPTH (2)
  ) u_op_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept),
    .wr_data   (op_in),
    .rd_en     (op_pop),
    .rd_data   (op_q),
    .not_empty (op_valid),
    .is_full   (op_full)
  );

  assign op = op_q;

endmodule

FILE: hw/rtl/tcw_back.sv
// Back end: screen store, cursor and the sequencer that carries out operations.
module tcw_back #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        attr,
  input  tcw_pkg::tcw_op_t  op,
  input  logic              op_valid,
  output logic              op_pop,
  input  logic              res_room,
  output logic              res_push,
  output tcw_pkg::tcw_res_t res,
  output logic              clearing
);

  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int ROW_W = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int MOD_W = $clog2(TAB_STOP);
  localparam int PW    = (AW > 11) ? AW : 11;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_WRAP,
    S_SCROLL,
    S_READ,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [AW-1:0]    clr_cnt_r;
  logic [COL_W-1:0] cur_col_r;
  logic [ROW_W-1:0] cur_row_r;
  logic [MOD_W-1:0] cur_mod_r;
  logic [ROW_W-1:0] top_r;
  logic [10:0]      shown_r;
  tcw_op_t          op_r;
  logic [COL_W-1:0] scroll_cnt_r;
  logic [ROW_W-1:0] scroll_row_r;
  logic [15:0]      cell_mem [CELLS];
  logic [15:0]      rdata_r;

  logic             dispatch;
  logic             fill_go;
  logic             we;
  logic [15:0]      wdata;
  logic [AW-1:0]    addr;
  logic [ROW_W-1:0] sel_row;
  logic [COL_W-1:0] sel_col;
  logic             sel_phys;
  logic [ROW_W:0]   row_sum;
  logic [ROW_W-1:0] phys_row;
  logic [MOD_W-1:0] mod_inc;
  logic [MOD_W-1:0] mod_dec;
  logic [PW-1:0]    pos_full;
  logic [10:0]      pos_nxt;

  assign dispatch = (state_r == S_IDLE) && op_valid && res_room;
  assign op_pop   = dispatch;
  assign clearing = (state_r == S_CLEAR);
  assign fill_go  = (cur_col_r < COL_W'(COLUMNS)) &&
                    ((op_r.kind == OP_LINE_END) || (cur_mod_r != '0));
  assign mod_inc  = (cur_mod_r == MOD_W'(TAB_STOP - 1)) ? '0 : cur_mod_r + 1'b1;
  assign mod_dec  = (cur_mod_r == '0) ? MOD_W'(TAB_STOP - 1) : cur_mod_r - 1'b1;
  assign pos_full = PW'(cur_row_r) * PW'(COLUMNS) + PW'(cur_col_r);
  assign pos_nxt  = pos_full[10:0];

  always_comb begin
    we       = 1'b0;
    wdata    = {attr, CH_BLANK};
    sel_row  = cur_row_r;
    sel_col  = cur_col_r;
    sel_phys = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (dispatch) begin
          unique case (op.kind)
            OP_PRINT: begin
              we    = 1'b1;
              wdata = {attr, op.ch};
            end
            OP_BACK: begin
              we      = (cur_col_r != '0);
              sel_col = cur_col_r - 1'b1;
            end
            OP_READ: begin
              sel_row = ROW_W'(op.row);
              sel_col = COL_W'(op.col);
            end
            default: begin
              we = 1'b0;
            end
          endcase
        end
      end
      S_FILL: begin
        we = fill_go;
      end
      S_SCROLL: begin
        we       = 1'b1;
        sel_phys = 1'b1;
        sel_col  = scroll_cnt_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    row_sum = (ROW_W + 1)'(top_r) + (ROW_W + 1)'(sel_row);
    if (sel_phys) begin
      phys_row = scroll_row_r;
    end else if (row_sum >= (ROW_W + 1)'(ROWS)) begin
      phys_row = ROW_W'(row_sum - (ROW_W + 1)'(ROWS));
    end else begin
      phys_row = ROW_W'(row_sum);
    end
    if (state_r == S_CLEAR) begin
      addr = clr_cnt_r;
    end else begin
      addr = AW'(phys_row) * AW'(COLUMNS) + AW'(sel_col);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      cell_mem[addr] <= {RESET_ATTR, CH_BLANK};
    end else if (we) begin
      cell_mem[addr] <= wdata;
    end
    rdata_r <= cell_mem[addr];
  end

  always_comb begin
    res.cursor_column    = 7'(cur_col_r);
    res.cursor_line      = 5'(cur_row_r);
    res.shown_cursor_pos = shown_r;
    res.cell_char        = 8'h00;
    res.cell_attr        = 8'h00;
    res_push             = 1'b0;
    if (state_r == S_DONE) begin
      res_push = 1'b1;
      if (op_r.last) begin
        res.shown_cursor_pos = pos_nxt;
      end
    end else if (state_r == S_READ) begin
      res_push = 1'b1;
      if (op_r.in_range) begin
        res.cell_char = rdata_r[7:0];
        res.cell_attr = rdata_r[15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      cur_col_r <= '0;
      cur_row_r <= '0;
      cur_mod_r <= '0;
      top_r     <= '0;
      shown_r   <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (dispatch) begin
            op_r <= op;
            unique case (op.kind)
              OP_READ: begin
                state_r <= S_READ;
              end
              OP_PRINT: begin
                cur_col_r <= cur_col_r + 1'b1;
                cur_mod_r <= mod_inc;
                state_r   <= S_WRAP;
              end
              OP_LINE_END: begin
                state_r <= S_FILL;
              end
              OP_TAB: begin
                cur_col_r <= cur_col_r + 1'b1;
                cur_mod_r <= mod_inc;
                state_r   <= S_FILL;
              end
              OP_BACK: begin
                if (cur_col_r != '0) begin
                  cur_col_r <= cur_col_r - 1'b1;
                  cur_mod_r <= mod_dec;
                end
                state_r <= S_WRAP;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_FILL: begin
          if (fill_go) begin
            cur_col_r <= cur_col_r + 1'b1;
            cur_mod_r <= mod_inc;
          end else begin
            state_r <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (cur_col_r >= COL_W'(COLUMNS)) begin
            cur_col_r <= '0;
            cur_mod_r <= '0;
            if (cur_row_r == ROW_W'(ROWS - 1)) begin
              scroll_row_r <= top_r;
              top_r        <= (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
              scroll_cnt_r <= '0;
              state_r      <= S_SCROLL;
            end else begin
              cur_row_r <= cur_row_r + 1'b1;
              state_r   <= S_DONE;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SCROLL: begin
          scroll_cnt_r <= scroll_cnt_r + 1'b1;
          if (scroll_cnt_r == COL_W'(COLUMNS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (op_r.last) begin
            shown_r <= pos_nxt;
          end
          state_r <= S_IDLE;
        end
        S_READ: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
